// ===== rtl/pixel_stream_width_converter_macros.svh =====
// Assertion macros for the pixel stream width converter checker.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PIXEL_STREAM_WIDTH_CONVERTER_MACROS_SVH
`define PIXEL_STREAM_WIDTH_CONVERTER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define PSWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent starting in the cycle after its antecedent.
`define PSWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pswc_pkg.sv =====
// Shared constants and types for the pixel stream width converter.
// No dependencies; imported by every RTL module of the block.
package pswc_pkg;

    // Pixel and word geometry, fixed by the port widths
    localparam int PIXEL_WIDTH = 8;
    localparam int IN_PIXELS   = 16;
    localparam int OUT_PIXELS  = 4;
    localparam int COUNT_WIDTH = 24;
    localparam int HALF_BITS   = 64;

    localparam int IN_BITS   = IN_PIXELS * PIXEL_WIDTH;
    localparam int WORD_BITS = OUT_PIXELS * PIXEL_WIDTH;
    localparam int CNT_IN_W  = $clog2(IN_PIXELS + 1);

    // Partial word held between input transactions
    localparam int PEND_CW   = $clog2(OUT_PIXELS);
    localparam int PEND_BITS = (OUT_PIXELS - 1) * PIXEL_WIDTH;
    localparam int PEND_SH_W = $clog2(PEND_BITS + 1);

    // Merged pixel stream: pending pixels plus one full input
    localparam int FILL_W       = $clog2(IN_PIXELS + OUT_PIXELS);
    localparam int STREAM_WORDS = (IN_PIXELS + 2 * OUT_PIXELS - 2) / OUT_PIXELS;
    localparam int STREAM_BITS  = STREAM_WORDS * WORD_BITS;
    localparam int NWORD_W      = $clog2(STREAM_WORDS + 1);
    localparam int WORD_SH_W    = $clog2(STREAM_BITS);

    // One burst of output words produced by a single input transaction
    typedef struct packed {
        logic [STREAM_BITS-1:0] stream;
        logic [NWORD_W-1:0]     words;
        logic                   last;
    } t_burst;

endpackage

// ===== rtl/pixel_stream_width_converter.sv =====
// Pixel stream width converter. Each input transaction carries up to 16
// 8-bit pixels (valid from pixel 0 upward); they are packed into 32-bit
// words of four pixels, earliest pixel in bits 7:0. A running pixel total,
// saturating at frame_pixels, ends the frame: the word that completes it
// carries last, and pixels still pending at that point leave in one
// zero-padded word with last. A transaction holds the burst register
// until its words have moved on, one 32-bit word per cycle unless i_ready
// stalls; a full 16-pixel input yields four words (five with a flush
// word). A new transaction is accepted in the cycle the previous burst
// hands over its final word. The user must write frame_pixels through
// i_cfg_we/i_cfg_wdata while the block is idle; the block does not check.
// Depends on pswc_pkg, pswc_merge and pswc_burst.
module pixel_stream_width_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pswc_pkg::COUNT_WIDTH-1:0] i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pswc_pkg::HALF_BITS-1:0]   i_pixels_low,
    input  logic [pswc_pkg::HALF_BITS-1:0]   i_pixels_high,
    input  logic [pswc_pkg::CNT_IN_W-1:0]    i_pixel_count,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pswc_pkg::WORD_BITS-1:0]   o_word,
    output logic                             o_last
);
    import pswc_pkg::*;

    logic [COUNT_WIDTH-1:0] r_frame_pixels;
    logic                   accept;
    t_burst                 burst;

    // Frame size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= '0;
        end else if (i_cfg_we) begin
            r_frame_pixels <= i_cfg_wdata;
        end
    end

    assign accept = i_valid && o_ready;

    pswc_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_frame_pixels (r_frame_pixels),
        .i_pixels_low   (i_pixels_low),
        .i_pixels_high  (i_pixels_high),
        .i_pixel_count  (i_pixel_count),
        .o_burst        (burst)
    );

    pswc_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_burst (burst),
        .o_free  (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word),
        .o_last  (o_last)
    );

endmodule

// ===== rtl/pswc_merge.sv =====
// Merge unit: appends the valid input pixels to the pending partial word,
// tracks the frame pixel total and builds the burst of output words.
// Depends on pswc_pkg.
module pswc_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [pswc_pkg::COUNT_WIDTH-1:0] i_frame_pixels,
    input  logic [pswc_pkg::HALF_BITS-1:0]   i_pixels_low,
    input  logic [pswc_pkg::HALF_BITS-1:0]   i_pixels_high,
    input  logic [pswc_pkg::CNT_IN_W-1:0]    i_pixel_count,
    output pswc_pkg::t_burst                 o_burst
);
    import pswc_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 1;

    logic [PEND_BITS-1:0]   r_pending, n_pending;
    logic [PEND_CW-1:0]     r_pend_cnt, n_pend_cnt;
    logic [COUNT_WIDTH-1:0] r_seen, n_seen;

    logic [CNT_IN_W-1:0]    take;
    logic [SUM_W-1:0]       sum;
    logic                   done;
    logic [IN_BITS-1:0]     in_pix;
    logic [IN_BITS-1:0]     in_kept;
    logic [STREAM_BITS-1:0] stream;
    logic [STREAM_BITS-1:0] rest;
    logic [FILL_W-1:0]      total;
    logic [NWORD_W-1:0]     full_words;
    logic [PEND_CW-1:0]     rem;

    // Clamp the count, update the saturating total
    always_comb begin
        take   = (i_pixel_count > CNT_IN_W'(IN_PIXELS)) ? CNT_IN_W'(IN_PIXELS)
                                                        : i_pixel_count;
        sum    = {1'b0, r_seen} + SUM_W'(take);
        n_seen = (sum > {1'b0, i_frame_pixels}) ? i_frame_pixels
                                                : sum[COUNT_WIDTH-1:0];
        done   = (n_seen == i_frame_pixels);
    end

    // Drop pixels above the valid count so padding reads as zero
    always_comb begin
        in_pix = {i_pixels_high, i_pixels_low};
        for (int k = 0; k < IN_PIXELS; k++) begin
            in_kept[k*PIXEL_WIDTH +: PIXEL_WIDTH] =
                (CNT_IN_W'(k) < take) ? in_pix[k*PIXEL_WIDTH +: PIXEL_WIDTH]
                                      : '0;
        end
    end

    // Append new pixels behind the pending ones and split into words
    always_comb begin
        stream = STREAM_BITS'(r_pending)
               | (STREAM_BITS'(in_kept)
                  << (PEND_SH_W'(r_pend_cnt) * PEND_SH_W'(PIXEL_WIDTH)));
        total      = FILL_W'(r_pend_cnt) + FILL_W'(take);
        full_words = NWORD_W'(total / OUT_PIXELS);
        rem        = PEND_CW'(total % OUT_PIXELS);
        rest       = stream >> (WORD_SH_W'(full_words) * WORD_SH_W'(WORD_BITS));

        // Flush the remainder as a padded word once the frame is complete
        n_pending  = done ? '0 : rest[PEND_BITS-1:0];
        n_pend_cnt = done ? '0 : rem;

        o_burst.stream = stream;
        o_burst.words  = full_words + NWORD_W'(done && (rem != '0));
        o_burst.last   = done;
    end

    // Advance the pending word and total on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_pend_cnt <= '0;
            r_seen     <= '0;
        end else if (i_accept) begin
            r_pending  <= n_pending;
            r_pend_cnt <= n_pend_cnt;
            r_seen     <= n_seen;
        end
    end

endmodule

// ===== rtl/pswc_burst.sv =====
// Burst emitter: holds one merged pixel stream and shifts it out one word
// per cycle into the output register when that is free. Depends on pswc_pkg.
module pswc_burst (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  pswc_pkg::t_burst               i_burst,
    output logic                           o_free,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [pswc_pkg::WORD_BITS-1:0] o_word,
    output logic                           o_last
);
    import pswc_pkg::*;

    logic [STREAM_BITS-1:0] r_stream;
    logic [NWORD_W-1:0]     r_left;
    logic                   r_blast;
    logic                   r_ovalid;
    logic [WORD_BITS-1:0]   r_oword;
    logic                   r_olast;
    logic                   move;

    // Move a word when one is left and the output register can take it
    always_comb begin
        move   = (r_left != '0) && (!r_ovalid || i_ready);
        o_free = (r_left == '0) || ((r_left == NWORD_W'(1)) && move);
    end

    // Hold the burst, shift it down as words leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_blast <= 1'b0;
        end else if (i_load) begin
            r_left  <= i_burst.words;
            r_blast <= i_burst.last;
        end else if (move) begin
            r_left  <= r_left - NWORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stream <= i_burst.stream;
        end else if (move) begin
            r_stream <= r_stream >> WORD_BITS;
        end
    end

    // Output register: load on move, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (move) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_oword <= r_stream[WORD_BITS-1:0];
            r_olast <= r_blast && (r_left == NWORD_W'(1));
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_oword;
    assign o_last  = r_olast;

endmodule

// ===== rtl/pswc_checker.sv =====
// Port-level checker for the pixel stream width converter, bound to the
// top level. Depends on pswc_pkg and the assertion macro header.
`include "pixel_stream_width_converter_macros.svh"

module pswc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [pswc_pkg::CNT_IN_W-1:0]    i_pixel_count,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [pswc_pkg::WORD_BITS-1:0]   o_word,
    input logic                             o_last
);
    import pswc_pkg::*;

    // Stalled output transaction holds its word and last flag
    `PSWC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_word) && $stable(o_last), "output changed while stalled")

    // A full input yields at least four words, so input stays blocked
    `PSWC_ASSERT_NEXT(a_full_blocks, i_valid && o_ready && i_pixel_count[CNT_IN_W-1], !o_ready, "ready after a full-width transaction")

    // Four or more input pixels reach o_valid via burst and output registers
    `PSWC_ASSERT_NEXT(a_word_follows, i_valid && o_ready && (i_pixel_count >= CNT_IN_W'(OUT_PIXELS)), ##1 o_valid, "no output word after input")

    // Busy with no word shown only right after an accepted transaction
    `PSWC_ASSERT_NOW(a_busy_source, !o_ready && !o_valid, $past(i_valid && o_ready), "input blocked without pending burst")

endmodule

bind pixel_stream_width_converter pswc_checker u_pswc_checker (.*);

// ===== sim/testbench.sv =====
// Testbench for pixel_stream_width_converter: random and directed pixel
// transactions checked word by word against a packing model in a scoreboard.
// Depends on pswc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

// Tracks the running pixel total and the partial word, and holds the words
// the block must still deliver.
class frame_word_board;
    localparam int REPORT_LIMIT = 10;

    logic [pswc_pkg::COUNT_WIDTH-1:0] frame_size;
    logic [pswc_pkg::COUNT_WIDTH-1:0] pixel_total;
    logic [pswc_pkg::WORD_BITS-1:0]   partial_word;
    int unsigned                      partial_count;

    logic [pswc_pkg::WORD_BITS-1:0]   word_q[$];
    logic                             last_q[$];

    int unsigned items_taken;
    int unsigned words_checked;
    int unsigned frame_ends;
    int unsigned mismatches;

    function new();
        frame_size    = '0;
        pixel_total   = '0;
        partial_word  = '0;
        partial_count = 0;
        items_taken   = 0;
        words_checked = 0;
        frame_ends    = 0;
        mismatches    = 0;
    endfunction

    function void set_frame(logic [pswc_pkg::COUNT_WIDTH-1:0] size);
        frame_size = size;
    endfunction

    function bit drained();
        return word_q.size() == 0;
    endfunction

    // Append the valid pixels of one accepted transaction; queue the words
    // it completes and a padded flush word once the frame total is reached.
    function void take_pixels(logic [pswc_pkg::HALF_BITS-1:0] lo,
                              logic [pswc_pkg::HALF_BITS-1:0] hi,
                              logic [pswc_pkg::CNT_IN_W-1:0]  count);
        logic [pswc_pkg::IN_BITS-1:0]   all_pixels;
        logic [pswc_pkg::COUNT_WIDTH:0] sum;
        int unsigned                    used;
        int unsigned                    i;
        bit                             done;

        all_pixels = {hi, lo};
        used = (count > pswc_pkg::IN_PIXELS) ? pswc_pkg::IN_PIXELS : count;
        items_taken++;

        // saturate the running total at the frame size
        sum = {1'b0, pixel_total} + used[pswc_pkg::COUNT_WIDTH:0];
        if (sum > frame_size)
            pixel_total = frame_size;
        else
            pixel_total = sum[pswc_pkg::COUNT_WIDTH-1:0];
        done = (pixel_total == frame_size);

        for (i = 0; i < used; i++) begin
            partial_word[partial_count*pswc_pkg::PIXEL_WIDTH +: pswc_pkg::PIXEL_WIDTH] =
                all_pixels[i*pswc_pkg::PIXEL_WIDTH +: pswc_pkg::PIXEL_WIDTH];
            partial_count++;
            if (partial_count == pswc_pkg::OUT_PIXELS) begin
                word_q.push_back(partial_word);
                last_q.push_back(done && (i + 1 == used));
                partial_word  = '0;
                partial_count = 0;
            end
        end

        // flush leftover pixels once the frame is complete
        if (done && partial_count > 0) begin
            word_q.push_back(partial_word);
            last_q.push_back(1'b1);
            partial_word  = '0;
            partial_count = 0;
        end
    endfunction

    // Compare one delivered word with the oldest expected one.
    function void check_word(logic [pswc_pkg::WORD_BITS-1:0] word, logic last);
        logic [pswc_pkg::WORD_BITS-1:0] exp_word;
        logic                           exp_last;

        words_checked++;
        if (last === 1'b1)
            frame_ends++;
        if (word_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("error: unexpected word %h last %b", word, last);
            return;
        end
        exp_word = word_q.pop_front();
        exp_last = last_q.pop_front();
        if (word !== exp_word || last !== exp_last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("error: word %h last %b, expected word %h last %b",
                         word, last, exp_word, exp_last);
        end
    endfunction
endclass

module testbench;
    import pswc_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE       = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 27;
    localparam logic [COUNT_WIDTH-1:0] FRAME_MAX = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [COUNT_WIDTH-1:0] i_cfg_wdata;
    logic                   i_valid;
    logic                   o_ready;
    logic [HALF_BITS-1:0]   i_pixels_low;
    logic [HALF_BITS-1:0]   i_pixels_high;
    logic [CNT_IN_W-1:0]    i_pixel_count;
    logic                   o_valid;
    logic                   i_ready;
    logic [WORD_BITS-1:0]   o_word;
    logic                   o_last;

    frame_word_board board;

    bit          tx_idling;
    bit          rx_idling;
    bit          hold_req;
    int unsigned stall_left;
    int unsigned quiet_cycles;

    pixel_stream_width_converter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixels_low  (i_pixels_low),
        .i_pixels_high (i_pixels_high),
        .i_pixel_count (i_pixel_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_word        (o_word),
        .o_last        (o_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Track both handshakes and stop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                board.take_pixels(i_pixels_low, i_pixels_high, i_pixel_count);
            if (o_valid && i_ready)
                board.check_word(o_word, o_last);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Drive output ready: random stall bursts, plus a long hold-off on request
    initial begin
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                i_ready    = 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (rx_idling && $urandom_range(0, 7) == 0) begin
                i_ready    = 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic send_pixels(logic [HALF_BITS-1:0] lo, logic [HALF_BITS-1:0] hi,
                               logic [CNT_IN_W-1:0] count);
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_pixels_low  = lo;
        i_pixels_high = hi;
        i_pixel_count = count;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_input(int unsigned cycles);
        @(negedge i_clk);
        i_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold the sender until every expected word has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (!board.drained()) @(posedge i_clk);
    endtask

    // Drain, then let an item with no output finish before a write
    task automatic settle_block();
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_frame(logic [COUNT_WIDTH-1:0] size);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = size;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_frame(size);
    endtask

    // Mostly full 16-pixel transactions, some partial, some over range
    task automatic send_random_item();
        logic [CNT_IN_W-1:0] count;
        int unsigned         pick;

        pick = $urandom_range(0, 9);
        if (pick <= 5)
            count = CNT_IN_W'(IN_PIXELS);
        else if (pick <= 7)
            count = CNT_IN_W'($urandom_range(0, IN_PIXELS - 1));
        else if (pick == 8)
            count = CNT_IN_W'($urandom_range(IN_PIXELS + 1, 31));
        else
            count = CNT_IN_W'($urandom_range(0, OUT_PIXELS - 1));
        send_pixels({$urandom(), $urandom()}, {$urandom(), $urandom()}, count);
        if (tx_idling && $urandom_range(0, 5) == 0)
            idle_input($urandom_range(1, 19));
    endtask

    initial begin
        logic [COUNT_WIDTH-1:0] size;
        int unsigned            phase;
        int unsigned            k;

        board         = new();
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_pixels_low  = '0;
        i_pixels_high = '0;
        i_pixel_count = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Frame size zero from reset: every item ends the frame, and one that leaves a partial word flushes it
        send_pixels('1, '1, 5'd16);
        send_pixels(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 5'd0);
        send_pixels(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 5'd3);
        send_pixels(64'h8877665544332211, 64'hffeeddccbbaa9988, 5'd5);
        send_pixels(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31);
        send_pixels('1, 64'h5555aaaa5555aaaa, 5'd17);
        settle_block();

        // Largest frame: pixels accumulate across items, no end reached
        write_frame(FRAME_MAX);
        send_pixels('0, '0, 5'd16);
        send_pixels(64'h00000000000000a1, '0, 5'd1);
        send_pixels(64'h000000000000b2c3, '0, 5'd2);
        send_pixels(64'h0000000000d4e5f6, '0, 5'd3);
        send_pixels('1, '1, 5'd0);
        send_pixels(64'haaaaaaaa55555555, 64'h33333333cccccccc, 5'd16);
        send_pixels(64'h7f80ff0001fe02fd, '1, 5'd4);
        settle_block();

        // Lower the frame below the total: clamped at the next item
        write_frame(24'd10);
        send_pixels(64'h0000000000313233, '0, 5'd3);
        send_pixels(64'h0000000041424344, '0, 5'd4);
        send_pixels('0, '0, 5'd0);
        settle_block();

        // Raise it again: exact frame end, then an end reached by saturating the total
        write_frame(24'd30);
        send_pixels({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd16);
        send_pixels(64'h0000000099887766, '0, 5'd4);
        settle_block();
        write_frame(24'd37);
        send_pixels({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd6);
        send_pixels({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd6);
        settle_block();

        // Random phases, each with its own frame size
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1:       size = FRAME_MAX;
                2:       size = '0;
                4:       size = board.pixel_total / 2;
                default: size = board.pixel_total
                              + COUNT_WIDTH'($urandom_range(40, 300));
            endcase
            write_frame(size);
            if (phase == PHASES - 1) begin
                tx_idling = 1'b0;
                rx_idling = 1'b0;
            end
            // keep the sender busy while the receiver holds off
            if (phase == 1) begin
                tx_idling = 1'b0;
                hold_req  = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 1 && k == PHASE_ITEMS / 2)
                    tx_idling = 1'b1;
                if (phase == 0 && k == PHASE_ITEMS / 2)
                    wait_drained();
                send_random_item();
            end
            settle_block();
        end

        $display("covered %0d transactions and %0d words (%0d marked last)",
                 board.items_taken, board.words_checked, board.frame_ends);
        $display("frame sizes included zero, the maximum, lowered and raised values");
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
